// ----- hw/rtl/scbc_pkg.sv -----
// types and constants shared by the swept circle / box collision core
// no dependencies
`default_nettype none

package scbc_pkg;

	typedef struct packed {
		logic signed [31:0] box_x;
		logic signed [31:0] box_y;
		logic signed [31:0] circle_x;
		logic signed [31:0] circle_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
	} item_t;

	typedef struct packed {
		logic        hit;
		logic        overlapping;
		logic [31:0] hit_time;
		logic        flip_y;
	} result_t;

	// sideband that rides along the divider
	typedef struct packed {
		item_t      item;
		logic       overlapping;
		logic [3:0] num_neg;
		logic [1:0] vel_neg;
		logic [1:0] vel_zero;
	} side_t;

	typedef enum logic [1:0] {
		CFG_HALF_WIDTH  = 2'd0,
		CFG_HALF_HEIGHT = 2'd1,
		CFG_RADIUS      = 2'd2
	} cfg_reg_t;

	localparam int CFG_W = 31;

	localparam logic [CFG_W-1:0] HALF_WIDTH_RST  = 31'd1966080;
	localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = 31'd655360;
	localparam logic [CFG_W-1:0] RADIUS_RST      = 31'd524288;

	// beyond any finite slab time
	localparam logic signed [63:0] T_INF = 64'sh4000_0000_0000_0000;

endpackage

`default_nettype wire

// ----- hw/rtl/scbc_div.sv -----
// four-lane pipelined restoring divider, one quotient bit per stage
// depends on scbc_pkg for the sideband type
`default_nettype none

module scbc_div #(
	parameter int NW = 50
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [NW-1:0]       in_num [4],
	input  logic [31:0]         in_den [4],
	input  scbc_pkg::side_t     in_side,
	output logic                out_valid,
	output logic [NW-1:0]       out_quo [4],
	output scbc_pkg::side_t     out_side
);

	logic                vld_s  [1:NW];
	logic [NW-1:0]       nq_s   [1:NW][4];
	logic [31:0]         rem_s  [1:NW][4];
	logic [31:0]         den_s  [1:NW][4];
	scbc_pkg::side_t     side_s [1:NW];

	for (genvar k = 1; k <= NW; k++) begin : g_stage
		logic            pv;
		logic [NW-1:0]   pnq  [4];
		logic [31:0]     prem [4];
		logic [31:0]     pden [4];
		scbc_pkg::side_t pside;
		logic [32:0]     sh   [4];
		logic            ge   [4];

		if (k == 1) begin : g_first
			always_comb begin
				pv    = in_valid;
				pside = in_side;
				for (int l = 0; l < 4; l++) begin
					pnq[l]  = in_num[l];
					prem[l] = '0;
					pden[l] = in_den[l];
				end
			end
		end else begin : g_next
			always_comb begin
				pv    = vld_s[k-1];
				pside = side_s[k-1];
				for (int l = 0; l < 4; l++) begin
					pnq[l]  = nq_s[k-1][l];
					prem[l] = rem_s[k-1][l];
					pden[l] = den_s[k-1][l];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < 4; l++) begin
				sh[l] = {prem[l], pnq[l][NW-1]};
				ge[l] = sh[l] >= {1'b0, pden[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 4; l++) begin
					rem_s[k][l] <= ge[l] ? 32'(sh[l] - {1'b0, pden[l]}) : sh[l][31:0];
					nq_s[k][l]  <= {pnq[l][NW-2:0], ge[l]};
					den_s[k][l] <= pden[l];
				end
				side_s[k] <= pside;
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign out_side  = side_s[NW];
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			out_quo[l] = nq_s[NW][l];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/scbc_reach.sv -----
// three-stage check that a circle moved by a slab time stays inside the
// grown extent on the other axis; no package dependencies
`default_nettype none

module scbc_reach #(
	parameter int NW        = 50,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] pos,
	input  logic signed [31:0] vel,
	input  logic signed [31:0] centre,
	input  logic [NW-1:0]      tm,
	input  logic [31:0]        limit,
	output logic               stays
);

	localparam int PW = NW + 32;

	logic [31:0]        vm;
	logic [63:0]        plo_s1;
	logic [NW-1:0]      phi_s1;
	logic               neg_s1;
	logic signed [65:0] base_s1;
	logic [PW-1:0]      prod_s2;
	logic               neg_s2;
	logic signed [65:0] base_s2;
	logic [63-FRAC_BITS:0] p;
	logic signed [65:0] sum;
	logic [65:0]        span;
	logic               ovf;
	logic               stays_s3;

	assign vm = vel[31] ? (~vel + 32'd1) : vel;

	// partial products, low and high halves of the time
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1  <= vm * tm[31:0];
			phi_s1  <= NW'(vm * tm[NW-1:32]);
			neg_s1  <= vel[31];
			base_s1 <= 66'(pos) - 66'(centre);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= {phi_s1, 32'd0} + PW'(plo_s1);
			neg_s2  <= neg_s1;
			base_s2 <= base_s1;
		end
	end

	always_comb begin
		ovf  = |prod_s2[PW-1:64];
		p    = prod_s2[63:FRAC_BITS];
		sum  = neg_s2 ? base_s2 - $signed({{(FRAC_BITS+2){1'b0}}, p})
		              : base_s2 + $signed({{(FRAC_BITS+2){1'b0}}, p});
		span = sum[65] ? 66'(-sum) : 66'(sum);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stays_s3 <= !ovf && (span < {34'd0, limit});
		end
	end

	assign stays = stays_s3;

endmodule

`default_nettype wire

// ----- hw/rtl/swept_circle_box_collision_core.sv -----
// throughput: one item per cycle while item_stall is low; depth set by the divider, one quotient bit per stage
// a skid register behind the output register absorbs one item while result_stall is high
// reset clears all valid bits and loads the box and radius registers with defaults
// uses scbc_pkg, scbc_div, scbc_reach
`default_nettype none

module swept_circle_box_collision_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  scbc_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output scbc_pkg::result_t            result,
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [scbc_pkg::CFG_W-1:0]   cfg_data
);

	localparam int NW = 34 + FRAC_BITS;

	logic [30:0] hw_q, hh_q, rad_q;
	logic        en, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q  <= scbc_pkg::HALF_WIDTH_RST;
			hh_q  <= scbc_pkg::HALF_HEIGHT_RST;
			rad_q <= scbc_pkg::RADIUS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				scbc_pkg::CFG_HALF_WIDTH:  hw_q  <= cfg_data;
				scbc_pkg::CFG_HALF_HEIGHT: hh_q  <= cfg_data;
				scbc_pkg::CFG_RADIUS:      rad_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [31:0] lim_x, lim_y;
	assign lim_x = {1'b0, hw_q} + {1'b0, rad_q};
	assign lim_y = {1'b0, hh_q} + {1'b0, rad_q};

	logic skid_valid_q;
	assign en         = !skid_valid_q;
	assign item_stall = skid_valid_q;
	assign accept     = item_valid && en;

	// stage 1: offsets and slab numerators
	logic signed [32:0] dx, dy;
	logic signed [34:0] rs, hws, hhs, cx_c, cy_c;
	logic               v_s1;
	scbc_pkg::item_t    item_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [34:0] n_s1 [4];

	always_comb begin
		dx   = 33'(item.box_x) - 33'(item.circle_x);
		dy   = 33'(item.box_y) - 33'(item.circle_y);
		rs   = $signed({4'd0, rad_q});
		hws  = $signed({4'd0, hw_q});
		hhs  = $signed({4'd0, hh_q});
		cx_c = dx[32] ? rs : -rs;
		cy_c = dy[32] ? rs : -rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
			dx_s1   <= dx;
			dy_s1   <= dy;
			n_s1[0] <= 35'(dx) - hws + cx_c;
			n_s1[1] <= 35'(dx) + hws + cx_c;
			n_s1[2] <= 35'(dy) - hhs + cy_c;
			n_s1[3] <= 35'(dy) + hhs + cy_c;
		end
	end

	// stage 2: magnitudes, signs, overlap test
	logic [32:0]     adx, ady;
	logic [33:0]     nm [4];
	logic            v_s2;
	logic [NW-1:0]   num_s2 [4];
	logic [31:0]     den_s2 [4];
	scbc_pkg::side_t side_s2;

	always_comb begin
		adx = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
		ady = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
		for (int l = 0; l < 4; l++) begin
			nm[l] = n_s1[l][34] ? 34'(-n_s1[l]) : 34'(n_s1[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				num_s2[l] <= {nm[l], {FRAC_BITS{1'b0}}};
				side_s2.num_neg[l] <= n_s1[l][34];
			end
			den_s2[0] <= item_s1.vel_x[31] ? (~item_s1.vel_x + 32'd1) : item_s1.vel_x;
			den_s2[1] <= item_s1.vel_x[31] ? (~item_s1.vel_x + 32'd1) : item_s1.vel_x;
			den_s2[2] <= item_s1.vel_y[31] ? (~item_s1.vel_y + 32'd1) : item_s1.vel_y;
			den_s2[3] <= item_s1.vel_y[31] ? (~item_s1.vel_y + 32'd1) : item_s1.vel_y;
			side_s2.item        <= item_s1;
			side_s2.overlapping <= (adx < {1'b0, lim_x}) && (ady < {1'b0, lim_y});
			side_s2.vel_neg     <= {item_s1.vel_y[31], item_s1.vel_x[31]};
			side_s2.vel_zero    <= {item_s1.vel_y == '0, item_s1.vel_x == '0};
		end
	end

	logic            v_dv;
	logic [NW-1:0]   quo [4];
	scbc_pkg::side_t side_dv;

	scbc_div #(.NW(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.in_num   (num_s2),
		.in_den   (den_s2),
		.in_side  (side_s2),
		.out_valid(v_dv),
		.out_quo  (quo),
		.out_side (side_dv)
	);

	// stage 3: signed slab times, zero velocity gives signed infinity
	logic              v_s3;
	logic signed [63:0] t_s3 [4];
	scbc_pkg::item_t   item_s3;
	logic              ovl_s3;
	logic [63:0]       q64 [4];
	logic              vz [4], qn [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			q64[l] = {{(64-NW){1'b0}}, quo[l]};
			vz[l]  = side_dv.vel_zero[l/2];
			qn[l]  = side_dv.num_neg[l] ^ side_dv.vel_neg[l/2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				if (vz[l]) begin
					t_s3[l] <= side_dv.num_neg[l] ? -scbc_pkg::T_INF : scbc_pkg::T_INF;
				end else begin
					t_s3[l] <= qn[l] ? -$signed(q64[l]) : $signed(q64[l]);
				end
			end
			item_s3 <= side_dv.item;
			ovl_s3  <= side_dv.overlapping;
		end
	end

	// stage 4: axis times
	logic signed [63:0] lo_x, hi_x, lo_y, hi_y, ax, ay;
	logic               v_s4;
	logic signed [63:0] xt_s4, yt_s4;
	scbc_pkg::item_t    item_s4;
	logic               ovl_s4, flip_s4, neg_s4;

	always_comb begin
		lo_x = (t_s3[0] < t_s3[1]) ? t_s3[0] : t_s3[1];
		hi_x = (t_s3[0] < t_s3[1]) ? t_s3[1] : t_s3[0];
		lo_y = (t_s3[2] < t_s3[3]) ? t_s3[2] : t_s3[3];
		hi_y = (t_s3[2] < t_s3[3]) ? t_s3[3] : t_s3[2];
		ax   = (lo_x > 0) ? lo_x : hi_x;
		ay   = (lo_y > 0) ? lo_y : hi_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xt_s4   <= ax;
			yt_s4   <= ay;
			item_s4 <= item_s3;
			ovl_s4  <= ovl_s3;
			flip_s4 <= ay < ax;
			neg_s4  <= ax[63] || ay[63];
		end
	end

	logic stays_x, stays_y;

	scbc_reach #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_reach_x (
		.clk   (clk),
		.en    (en),
		.pos   (item_s4.circle_y),
		.vel   (item_s4.vel_y),
		.centre(item_s4.box_y),
		.tm    (xt_s4[NW-1:0]),
		.limit (lim_y),
		.stays (stays_x)
	);

	scbc_reach #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_reach_y (
		.clk   (clk),
		.en    (en),
		.pos   (item_s4.circle_x),
		.vel   (item_s4.vel_x),
		.centre(item_s4.box_x),
		.tm    (yt_s4[NW-1:0]),
		.limit (lim_x),
		.stays (stays_y)
	);

	// stages 5 to 7 run beside the extent check
	logic               v_s5, v_s6, v_s7;
	logic signed [63:0] xt_s5, yt_s5, xt_s6, yt_s6, xt_s7, yt_s7;
	logic [2:0]         fl_s5, fl_s6, fl_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xt_s5 <= xt_s4;
			yt_s5 <= yt_s4;
			fl_s5 <= {ovl_s4, neg_s4, flip_s4};
			xt_s6 <= xt_s5;
			yt_s6 <= yt_s5;
			fl_s6 <= fl_s5;
			xt_s7 <= xt_s6;
			yt_s7 <= yt_s6;
			fl_s7 <= fl_s6;
		end
	end

	// final selection
	logic signed [63:0] xe, ye, best;
	scbc_pkg::result_t  res;

	always_comb begin
		xe   = ((xt_s7 < scbc_pkg::T_INF) && !stays_x) ? scbc_pkg::T_INF : xt_s7;
		ye   = ((yt_s7 < scbc_pkg::T_INF) && !stays_y) ? scbc_pkg::T_INF : yt_s7;
		best = (xe < ye) ? xe : ye;
		res.flip_y      = fl_s7[0];
		res.overlapping = 1'b0;
		res.hit         = 1'b0;
		res.hit_time    = '1;
		if (fl_s7[2]) begin
			res.overlapping = 1'b1;
		end else if (!fl_s7[1] && (best < scbc_pkg::T_INF)) begin
			res.hit      = 1'b1;
			res.hit_time = (best > 64'sh0000_0000_FFFF_FFFF) ? '1 : best[31:0];
		end
	end

	// output register with skid
	scbc_pkg::result_t result_q, skid_q;
	logic              result_valid_q, take;

	assign take = result_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (en && v_s7) begin
			if (!result_valid_q || take) begin
				result_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q && (!result_valid_q || take)) begin
			result_valid_q <= 1'b1;
			skid_valid_q   <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s7) begin
			if (!result_valid_q || take) begin
				result_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (skid_valid_q && (!result_valid_q || take)) begin
			result_q <= skid_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- hw/rtl/scbc_checker.sv -----
// port-level checks for the swept circle / box collision core, bound to the top
// depends on scbc_pkg
`default_nettype none

module scbc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input scbc_pkg::item_t            item,
	input logic                       result_valid,
	input logic                       result_stall,
	input scbc_pkg::result_t          result
);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !result_valid && !item_stall)
		else $error("outputs active in reset");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled input item changed");

	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.hit && result.overlapping))
		else $error("hit and overlap together");

	a_miss_ones: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |-> result.hit_time == 32'hFFFF_FFFF)
		else $error("miss without all-ones time");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled item changed");

endmodule

bind swept_circle_box_collision_core scbc_checker u_scbc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.item        (item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

`default_nettype wire
